// ===== rtl/coi_pkg.sv =====
`default_nettype none
package coi_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_OFFSET = 2'd2,
    CMD_CONV   = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ENDS_RD,
    ST_ENDS_WAIT,
    ST_INS_RD,
    ST_INS_WAIT,
    ST_INS_CHK,
    ST_INS_PUT,
    ST_OFS_START,
    ST_OFS_EDGE,
    ST_BS_RD,
    ST_BS_WAIT,
    ST_BS_STEP,
    ST_PAIR_RD,
    ST_PAIR_WAIT,
    ST_MUL,
    ST_DIV,
    ST_ROUND,
    ST_CONV_STEP,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic clear_cnt;
    logic ins_shift;
    logic ins_put;
    logic ends_rd;
    logic ends_cap;
    logic ofs_start;
    logic ofs_edge;
    logic bs_step;
    logic pair_rd;
    logic pair_cap;
    logic mul_step;
    logic div_step;
    logic round_step;
    logic conv_step;
    logic finish;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic     full;
    logic     empty;
    logic     ins_stop;
    logic     edge_hit;
    logic     pair_hit;
    logic     bs_done;
    logic     mul_done;
    logic     div_done;
    logic     conv_done;
    cmd_t     cmd;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/coi_ram.sv =====
`default_nettype none
module coi_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/coi_ctrl.sv =====
`default_nettype none
module coi_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  input  wire coi_pkg::stat_t st,
  output coi_pkg::ctrl_t     ctl
);
  coi_pkg::state_t state, state_next;
  logic out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= coi_pkg::ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.finish) out_full <= 1'b1;
      else if (m_tready) out_full <= 1'b0;
    end
  end

  assign m_tvalid = out_full;
  // next item may enter while the result still waits
  assign s_tready = (state == coi_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      coi_pkg::ST_IDLE: if (s_tvalid) begin
        state_next = coi_pkg::ST_DONE;
        case (st.cmd)
          coi_pkg::CMD_CLEAR:  state_next = coi_pkg::ST_DONE;
          coi_pkg::CMD_INSERT: state_next = st.full ? coi_pkg::ST_ENDS_RD : coi_pkg::ST_INS_RD;
          default:             state_next = coi_pkg::ST_OFS_START;
        endcase
      end
      coi_pkg::ST_INS_RD:   state_next = coi_pkg::ST_INS_WAIT;
      coi_pkg::ST_INS_WAIT: state_next = coi_pkg::ST_INS_CHK;
      coi_pkg::ST_INS_CHK:  state_next = st.ins_stop ? coi_pkg::ST_INS_PUT : coi_pkg::ST_INS_RD;
      coi_pkg::ST_INS_PUT:  state_next = coi_pkg::ST_ENDS_RD;
      coi_pkg::ST_OFS_START:
        state_next = st.empty ? coi_pkg::ST_ENDS_RD : coi_pkg::ST_OFS_EDGE;
      coi_pkg::ST_OFS_EDGE:
        state_next = st.edge_hit ? coi_pkg::ST_CONV_STEP : coi_pkg::ST_BS_RD;
      coi_pkg::ST_BS_RD:    state_next = coi_pkg::ST_BS_WAIT;
      coi_pkg::ST_BS_WAIT:  state_next = coi_pkg::ST_BS_STEP;
      coi_pkg::ST_BS_STEP:  state_next = st.bs_done ? coi_pkg::ST_PAIR_RD : coi_pkg::ST_BS_RD;
      coi_pkg::ST_PAIR_RD:  state_next = coi_pkg::ST_PAIR_WAIT;
      coi_pkg::ST_PAIR_WAIT:
        state_next = st.pair_hit ? coi_pkg::ST_CONV_STEP : coi_pkg::ST_MUL;
      coi_pkg::ST_MUL:      state_next = st.mul_done ? coi_pkg::ST_DIV : coi_pkg::ST_MUL;
      coi_pkg::ST_DIV:      state_next = st.div_done ? coi_pkg::ST_ROUND : coi_pkg::ST_DIV;
      coi_pkg::ST_ROUND:    state_next = coi_pkg::ST_CONV_STEP;
      coi_pkg::ST_CONV_STEP:
        state_next = st.conv_done ? coi_pkg::ST_ENDS_RD : coi_pkg::ST_OFS_START;
      coi_pkg::ST_ENDS_RD:   state_next = st.empty ? coi_pkg::ST_DONE : coi_pkg::ST_ENDS_WAIT;
      coi_pkg::ST_ENDS_WAIT: state_next = coi_pkg::ST_DONE;
      coi_pkg::ST_DONE:     if (!out_full || m_tready) state_next = coi_pkg::ST_IDLE;
      default:              state_next = coi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      coi_pkg::ST_IDLE: begin
        ctl.load_in   = s_tvalid;
        ctl.clear_cnt = s_tvalid && (st.cmd == coi_pkg::CMD_CLEAR);
      end
      coi_pkg::ST_INS_CHK:   ctl.ins_shift = 1'b1;
      coi_pkg::ST_INS_PUT:   ctl.ins_put = 1'b1;
      coi_pkg::ST_OFS_START: ctl.ofs_start = 1'b1;
      coi_pkg::ST_OFS_EDGE:  ctl.ofs_edge = 1'b1;
      coi_pkg::ST_BS_STEP:   ctl.bs_step = 1'b1;
      coi_pkg::ST_PAIR_RD:   ctl.pair_rd = 1'b1;
      coi_pkg::ST_PAIR_WAIT: ctl.pair_cap = 1'b1;
      coi_pkg::ST_MUL:       ctl.mul_step = 1'b1;
      coi_pkg::ST_DIV:       ctl.div_step = 1'b1;
      coi_pkg::ST_ROUND:     ctl.round_step = 1'b1;
      coi_pkg::ST_CONV_STEP: ctl.conv_step = 1'b1;
      coi_pkg::ST_ENDS_RD:   ctl.ends_rd = 1'b1;
      coi_pkg::ST_ENDS_WAIT: ctl.ends_cap = 1'b1;
      coi_pkg::ST_DONE:      ctl.finish = !out_full || m_tready;
      default:               ctl = '0;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !ctl.finish) else $error("ready while finishing");
  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> m_tvalid) else $error("result lost");
  a_one_ins: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.ins_put, ctl.ins_shift, ctl.div_step, ctl.mul_step}))
    else $error("datapath commands overlap");
endmodule
`default_nettype wire

// ===== rtl/coi_dp.sv =====
`default_nettype none
module coi_dp #(
  parameter int MAX_SAMPLES    = 64,
  parameter int MAX_ITERATIONS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire coi_pkg::ctrl_t      ctl,
  output coi_pkg::stat_t           st,
  input  wire logic [1:0]          in_command,
  input  wire logic signed [63:0]  in_time,
  input  wire logic signed [63:0]  in_offset,
  output logic [63:0]              value_ns,
  output logic                     covered,
  output logic [63:0]              first_host_ns,
  output logic [63:0]              last_host_ns,
  output logic [6:0]               sample_count,
  output logic                     insert_dropped,
  output logic                     converged
);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int IW = $clog2(MAX_ITERATIONS + 1);

  // table in two memories: one for shifting reads, one for search reads
  logic [CW-1:0] count;
  logic [1:0]    cmd;
  logic signed [63:0] t_in, off_in;

  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [127:0]  wdata, rd_a, rd_b;

  coi_ram #(.WIDTH(128), .DEPTH(MAX_SAMPLES)) u_ram_a (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr_a), .rdata(rd_a));
  coi_ram #(.WIDTH(128), .DEPTH(MAX_SAMPLES)) u_ram_b (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr_b), .rdata(rd_b));

  // separate end-sample copies in registers
  logic signed [63:0] first_t, last_t, first_o, last_o;

  logic [CW-1:0] pos;
  logic signed [63:0] q_t;   // query time
  logic [63:0] host;
  logic [IW-1:0] iter;
  logic conv_seed, conv_ok;
  logic [CW-1:0] lo_i, hi_i;
  logic signed [63:0] lo_o;
  logic [63:0] ofs_val;
  logic [63:0] span, gap, mag;
  logic        neg;
  logic [127:0] prod, prod_next;
  logic [6:0]  mcnt;
  logic [63:0] rem, quo, dlo;
  logic        dropped;

  logic [CW-1:0] mid;
  assign mid = lo_i + ((hi_i - lo_i) >> 1);

  always_comb begin
    we      = 1'b0;
    waddr   = pos[AW-1:0];
    wdata   = rd_a;
    raddr_a = AW'(pos - CW'(1));
    raddr_b = mid[AW-1:0];
    if (ctl.ins_shift && !st.ins_stop) begin
      we = 1'b1;
    end else if (ctl.ins_put) begin
      we    = 1'b1;
      wdata = {off_in, t_in};
    end
    if (ctl.pair_rd) begin
      raddr_a = AW'(hi_i - CW'(1));
      raddr_b = hi_i[AW-1:0];
    end
    if (ctl.ends_rd) begin
      raddr_a = '0;
      raddr_b = AW'(count - CW'(1));
    end
  end

  assign st.full     = (count == CW'(MAX_SAMPLES));
  assign st.empty    = (count == '0);
  assign st.ins_stop = (pos == '0) || !($signed(rd_a[63:0]) > t_in);
  // query clamps at either end of the table
  assign st.edge_hit = (q_t <= first_t) || (q_t >= last_t);
  // equal neighbor times, or query at or past the upper neighbor
  assign st.pair_hit = ($signed(rd_b[63:0]) <= $signed(rd_a[63:0]))
                       || ((q_t - rd_a[63:0]) >= (rd_b[63:0] - rd_a[63:0]));
  assign st.bs_done  = (lo_i >= hi_i);
  assign st.mul_done = (mcnt == 7'd63);
  assign st.div_done = (mcnt == 7'd63);
  assign st.cmd      = coi_pkg::cmd_t'(in_command);

  logic [63:0] next_host, rnd_q;
  logic [64:0] r_sh;
  logic [63:0] r_sub;
  logic        r_ge;
  assign next_host = t_in - ofs_val;
  assign r_sh  = {rem, dlo[63]};
  assign r_ge  = r_sh[64] || (r_sh[63:0] >= span);
  assign r_sub = r_sh[63:0] - span;
  assign rnd_q = (rem >= span - rem) ? quo + 64'd1 : quo;
  assign prod_next = (prod << 1) + (gap[63 - mcnt[5:0]] ? {64'd0, mag} : 128'd0);

  always_comb begin
    st.conv_done = 1'b1;
    if (cmd == coi_pkg::CMD_CONV) begin
      if (conv_seed) st.conv_done = (MAX_ITERATIONS == 0);
      else st.conv_done = (next_host == host) || (iter == IW'(MAX_ITERATIONS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (ctl.clear_cnt) count <= '0;
      if (ctl.ins_put) count <= count + CW'(1);
    end
    if (ctl.load_in) begin
      cmd     <= in_command;
      t_in    <= in_time;
      off_in  <= in_offset;
      pos     <= count;
      q_t     <= in_time;
      iter    <= '0;
      conv_seed <= 1'b1;
      conv_ok <= 1'b0;
      dropped <= (in_command == coi_pkg::CMD_INSERT) && (count == CW'(MAX_SAMPLES));
      ofs_val <= '0;
      host    <= in_time;
    end
    if (ctl.ins_shift && !st.ins_stop) pos <= pos - CW'(1);
    if (ctl.ofs_start) begin
      lo_i <= '0;
      hi_i <= count - CW'(1);
      if (count == '0) begin
        ofs_val <= '0;
        conv_ok <= 1'b1;
      end
    end
    if (ctl.ofs_edge) begin
      if (q_t <= first_t) ofs_val <= first_o;
      else if (q_t >= last_t) ofs_val <= last_o;
    end
    if (ctl.bs_step && !st.bs_done) begin
      if ($signed(rd_b[63:0]) > q_t) hi_i <= mid;
      else lo_i <= mid + CW'(1);
    end
    // pair data arrives in the cycle after pair_rd
    if (ctl.pair_cap) begin
      lo_o <= $signed(rd_a[127:64]);
      if ($signed(rd_b[63:0]) <= $signed(rd_a[63:0])) begin
        ofs_val <= rd_a[127:64];
      end else if ((q_t - rd_a[63:0]) >= (rd_b[63:0] - rd_a[63:0])) begin
        ofs_val <= rd_b[127:64];
      end
      span <= rd_b[63:0] - rd_a[63:0];
      gap  <= q_t - rd_a[63:0];
      neg  <= $signed(rd_b[127:64]) < $signed(rd_a[127:64]);
      mag  <= ($signed(rd_b[127:64]) < $signed(rd_a[127:64])) ?
              rd_a[127:64] - rd_b[127:64] : rd_b[127:64] - rd_a[127:64];
      prod <= '0;
      mcnt <= '0;
    end
    // shift-add multiply, one bit of gap per cycle, msb first
    if (ctl.mul_step) begin
      prod <= prod_next;
      if (mcnt == 7'd63) begin
        mcnt <= '0;
        rem  <= prod_next[127:64];
        dlo  <= prod_next[63:0];
        quo  <= '0;
      end else mcnt <= mcnt + 7'd1;
    end
    // restoring divide, one quotient bit per cycle
    if (ctl.div_step) begin
      rem <= r_ge ? r_sub : r_sh[63:0];
      quo <= {quo[62:0], r_ge};
      dlo <= dlo << 1;
      mcnt <= (mcnt == 7'd63) ? '0 : mcnt + 7'd1;
    end
    if (ctl.round_step) begin
      ofs_val <= neg ? lo_o - rnd_q : lo_o + rnd_q;
    end
    if (ctl.conv_step && cmd == coi_pkg::CMD_CONV) begin
      if (conv_seed) begin
        conv_seed <= 1'b0;
        host <= next_host;
        q_t  <= next_host;
      end else if (next_host == host) begin
        conv_ok <= 1'b1;
      end else begin
        host <= next_host;
        q_t  <= next_host;
        iter <= iter + IW'(1);
      end
    end
    if (ctl.ends_cap) begin
      first_t <= $signed(rd_a[63:0]); first_o <= $signed(rd_a[127:64]);
      last_t  <= $signed(rd_b[63:0]);  last_o  <= $signed(rd_b[127:64]);
    end
    if (ctl.finish) begin
      value_ns <= (cmd == coi_pkg::CMD_OFFSET) ? ofs_val :
                  (cmd == coi_pkg::CMD_CONV) ? host : 64'd0;
      converged <= (cmd == coi_pkg::CMD_CONV) && (conv_ok || count == '0);
      insert_dropped <= dropped;
      sample_count <= 7'(count);
      if (count == '0) begin
        first_host_ns <= '0; last_host_ns <= '0; covered <= 1'b0;
      end else begin
        first_host_ns <= first_t; last_host_ns <= last_t;
        covered <= (t_in >= first_t) && (t_in <= last_t);
      end
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES)) else $error("count overflow");
  a_put_room: assert property (@(posedge clk) disable iff (rst)
    ctl.ins_put |-> !st.full) else $error("insert into full table");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_cnt |=> count == '0) else $error("clear failed");
endmodule
`default_nettype wire

// ===== rtl/clock_offset_interpolator_core.sv =====
// clear resets the count; an insert into a full table is dropped; an insert moves later samples
// up one slot each, then writes the new one; an offset query clamps at an end, else runs a binary
// search, a shift-add multiply and a restoring divide; conversion takes up to 33 evaluations
// one item at a time; the next item is taken while a result waits
// rst is synchronous active high and empties the table; stored samples are
// not cleared
`default_nettype none
module clock_offset_interpolator_core #(
  parameter int MAX_SAMPLES    = 64,
  parameter int MAX_ITERATIONS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [135:0] s_tdata,  // command[1:0], time_ns[65:2], offset_ns[129:66], zeros
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [199:0]      m_tdata   // value_ns[63:0], covered[64], first_host_ns[128:65],
                                      // last_host_ns[192:129], sample_count[199:193]
  ,output logic [1:0]       m_tuser   // insert_dropped[0], converged[1]
);
  coi_pkg::ctrl_t ctl;
  coi_pkg::stat_t st;
  logic [63:0] value_ns, first_host_ns, last_host_ns;
  logic        covered, insert_dropped, converged;
  logic [6:0]  sample_count;

  coi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .st(st), .ctl(ctl));

  coi_dp #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_ITERATIONS(MAX_ITERATIONS)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .st(st),
    .in_command(s_tdata[1:0]), .in_time(s_tdata[65:2]), .in_offset(s_tdata[129:66]),
    .value_ns(value_ns), .covered(covered), .first_host_ns(first_host_ns),
    .last_host_ns(last_host_ns), .sample_count(sample_count),
    .insert_dropped(insert_dropped), .converged(converged));

  assign m_tdata = {sample_count, last_host_ns, first_host_ns, covered, value_ns};
  assign m_tuser = {converged, insert_dropped};
endmodule
`default_nettype wire
